[sv/tt_pkg.sv]
// Shared types and constants for the text tokenizer.
package tt_pkg;

  localparam int TOKEN_BUFFER = 128;
  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int MAX_RESULTS  = 3;

  localparam logic [7:0]  WS_MAX    = 8'd32;
  localparam logic [7:0]  CH_NUL    = 8'h00;
  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_SLASH  = 8'h2F;
  localparam logic [19:0] LINE_MAX  = 20'hFFFFF;
  localparam logic [19:0] LINE_ONE  = 20'd1;
  // add_char fails once the token would grow past TOKEN_BUFFER - 1 characters
  localparam logic [6:0]  LEN_LIMIT = 7'(TOKEN_BUFFER - 1);

  localparam logic FUNC_TEXT    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [2:0] {
    M_SKIP    = 3'd0,
    M_SLASH   = 3'd1,
    M_COMMENT = 3'd2,
    M_PLAIN   = 3'd3,
    M_QUOTED  = 3'd4,
    M_HALT    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    K_CHAR  = 2'd0,
    K_END   = 2'd1,
    K_EOD   = 2'd2,
    K_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    E_LINE     = 2'd0,
    E_QUOTE    = 2'd1,
    E_TOO_LONG = 2'd2,
    E_NONE     = 2'd3
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch;
    logic [1:0]  err;
    logic [19:0] line;
    logic [6:0]  len;
    logic        last;
  } result_t;

  function automatic result_t mk_res(kind_t k, logic [7:0] c, err_t e,
                                     logic [19:0] ln, logic [6:0] len);
    result_t r;
    r.kind = k;
    r.ch   = (k == K_CHAR) ? c : 8'd0;
    r.err  = (k == K_ERROR) ? e : 2'd0;
    r.line = ln;
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

[sv/text_tokenizer.sv]
// Streaming tokenizer: one text byte per transfer in, token events out.
//
// Input channel (item_valid / item_stall): func, text_byte, allow_line_break.
// func restart sets the line count to 1 and clears the scan state, giving
// no result. A text byte gives zero to three results.
// Output channel (result_valid / result_stall): kind, char_out, error_code,
// line_number, token_length, last; last marks the final result of a byte.
// An accepted byte is held in an input register, is decoded in one pass
// against the scan state and its results are written to an 8-entry
// result queue. The first result is valid once it is written to the queue
// and is taken when result_stall is low.
// One byte can be taken every cycle while item_stall is low; the sustained
// rate is bounded by the output port, which moves one result per cycle
// while result_stall is low, and each result of a byte needs its own transfer.
// item_stall rises when the queue holds more than two results, leaving room
// for the byte in the input register and one more; a stalled receiver thus
// backs up into the input after a few transfers, nothing is dropped.
// Reset (rst, synchronous) empties the queue and sets the scan state to
// skipping whitespace, line 1, length 0. After an error every text byte is
// consumed without result until a restart.
module text_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [7:0]  text_byte,
  input  logic        allow_line_break,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  char_out,
  output logic [1:0]  error_code,
  output logic [19:0] line_number,
  output logic [6:0]  token_length,
  output logic        last
);

  localparam int CW = tt_pkg::FIFO_AW + 1;
  localparam logic [CW-1:0] STALL_LEVEL = CW'(tt_pkg::FIFO_DEPTH - 2 * tt_pkg::MAX_RESULTS);

  // input register
  logic       p_valid;
  logic       p_func;
  logic [7:0] p_byte;
  logic       p_allow;

  // scan state
  tt_pkg::mode_t mode, mode_next;
  logic [19:0]   line_count, line_next;
  logic [6:0]    length_count, len_next;

  // results of the current byte
  tt_pkg::result_t res [tt_pkg::MAX_RESULTS];
  logic [1:0]      n;

  // result queue
  tt_pkg::result_t             fifo [tt_pkg::FIFO_DEPTH];
  logic [tt_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [tt_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [CW-1:0]               count;

  logic item_take;
  logic result_take;

  assign item_stall  = count > STALL_LEVEL;
  assign item_take   = item_valid && !item_stall;
  assign result_valid = count != '0;
  assign result_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= item_take;
    end
    if (item_take) begin
      p_func  <= func;
      p_byte  <= text_byte;
      p_allow <= allow_line_break;
    end
  end

  always_comb begin
    logic do_plain;
    logic do_skip;
    logic do_add;
    logic ws;
    do_plain  = 1'b0;
    do_skip   = 1'b0;
    do_add    = 1'b0;
    ws        = p_byte <= tt_pkg::WS_MAX;
    mode_next = mode;
    line_next = line_count;
    len_next  = length_count;
    n         = 2'd0;
    for (int i = 0; i < tt_pkg::MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    if (p_valid) begin
      if (p_func == tt_pkg::FUNC_RESTART) begin
        mode_next = tt_pkg::M_SKIP;
        line_next = tt_pkg::LINE_ONE;
        len_next  = '0;
      end else begin
        unique case (mode)
          tt_pkg::M_SKIP: begin
            do_skip = 1'b1;
          end
          tt_pkg::M_SLASH: begin
            if (p_byte == tt_pkg::CH_SLASH) begin
              if (!p_allow) begin
                res[n] = tt_pkg::mk_res(tt_pkg::K_ERROR, 8'd0, tt_pkg::E_LINE,
                                        line_next, len_next);
                n = n + 2'd1;
                mode_next = tt_pkg::M_HALT;
              end else begin
                mode_next = tt_pkg::M_COMMENT;
              end
            end else begin
              // lone slash: it opens a plain token, which this byte continues or, if whitespace, ends
              mode_next = tt_pkg::M_PLAIN;
              if (len_next >= tt_pkg::LEN_LIMIT) begin
                res[n] = tt_pkg::mk_res(tt_pkg::K_ERROR, 8'd0, tt_pkg::E_TOO_LONG,
                                        line_next, len_next);
                n = n + 2'd1;
                mode_next = tt_pkg::M_HALT;
              end else begin
                len_next = len_next + 7'd1;
                res[n] = tt_pkg::mk_res(tt_pkg::K_CHAR, tt_pkg::CH_SLASH,
                                        tt_pkg::E_NONE, line_next, len_next);
                n = n + 2'd1;
                do_plain = 1'b1;
              end
            end
          end
          tt_pkg::M_COMMENT: begin
            if (p_byte == tt_pkg::CH_NUL || p_byte == tt_pkg::CH_LF) begin
              if (!p_allow) begin
                res[n] = tt_pkg::mk_res(tt_pkg::K_ERROR, 8'd0, tt_pkg::E_LINE,
                                        line_next, len_next);
                n = n + 2'd1;
                mode_next = tt_pkg::M_HALT;
              end else if (p_byte == tt_pkg::CH_NUL) begin
                len_next  = '0;
                mode_next = tt_pkg::M_SKIP;
                res[n] = tt_pkg::mk_res(tt_pkg::K_EOD, 8'd0, tt_pkg::E_NONE,
                                        line_next, len_next);
                n = n + 2'd1;
              end else begin
                if (line_next != tt_pkg::LINE_MAX) line_next = line_next + 20'd1;
                mode_next = tt_pkg::M_SKIP;
              end
            end
          end
          tt_pkg::M_PLAIN: begin
            do_plain = 1'b1;
          end
          tt_pkg::M_QUOTED: begin
            if (p_byte == tt_pkg::CH_QUOTE) begin
              res[n] = tt_pkg::mk_res(tt_pkg::K_END, 8'd0, tt_pkg::E_NONE,
                                      line_next, len_next);
              n = n + 2'd1;
              mode_next = tt_pkg::M_SKIP;
            end else if (p_byte == tt_pkg::CH_NUL) begin
              res[n] = tt_pkg::mk_res(tt_pkg::K_ERROR, 8'd0, tt_pkg::E_QUOTE,
                                      line_next, len_next);
              n = n + 2'd1;
              mode_next = tt_pkg::M_HALT;
            end else begin
              do_add = 1'b1;
            end
          end
          tt_pkg::M_HALT: begin
          end
          default: begin
            mode_next = tt_pkg::M_HALT;
          end
        endcase

        if (do_plain) begin
          if (ws) begin
            // terminator closes the token and is then treated as whitespace
            res[n] = tt_pkg::mk_res(tt_pkg::K_END, 8'd0, tt_pkg::E_NONE,
                                    line_next, len_next);
            n = n + 2'd1;
            mode_next = tt_pkg::M_SKIP;
            do_skip   = 1'b1;
          end else begin
            do_add = 1'b1;
          end
        end

        if (do_skip) begin
          if (p_byte == tt_pkg::CH_NUL) begin
            if (!p_allow) begin
              res[n] = tt_pkg::mk_res(tt_pkg::K_ERROR, 8'd0, tt_pkg::E_LINE,
                                      line_next, len_next);
              n = n + 2'd1;
              mode_next = tt_pkg::M_HALT;
            end else begin
              len_next  = '0;
              mode_next = tt_pkg::M_SKIP;
              res[n] = tt_pkg::mk_res(tt_pkg::K_EOD, 8'd0, tt_pkg::E_NONE,
                                      line_next, len_next);
              n = n + 2'd1;
            end
          end else if (ws) begin
            if (p_byte == tt_pkg::CH_LF) begin
              if (!p_allow) begin
                res[n] = tt_pkg::mk_res(tt_pkg::K_ERROR, 8'd0, tt_pkg::E_LINE,
                                        line_next, len_next);
                n = n + 2'd1;
                mode_next = tt_pkg::M_HALT;
              end else if (line_next != tt_pkg::LINE_MAX) begin
                line_next = line_next + 20'd1;
              end
            end
          end else if (p_byte == tt_pkg::CH_QUOTE) begin
            len_next  = '0;
            mode_next = tt_pkg::M_QUOTED;
          end else if (p_byte == tt_pkg::CH_SLASH) begin
            len_next  = '0;
            mode_next = tt_pkg::M_SLASH;
          end else begin
            len_next  = '0;
            mode_next = tt_pkg::M_PLAIN;
            do_add    = 1'b1;
          end
        end

        if (do_add) begin
          if (len_next >= tt_pkg::LEN_LIMIT) begin
            res[n] = tt_pkg::mk_res(tt_pkg::K_ERROR, 8'd0, tt_pkg::E_TOO_LONG,
                                    line_next, len_next);
            n = n + 2'd1;
            mode_next = tt_pkg::M_HALT;
          end else begin
            len_next = len_next + 7'd1;
            res[n] = tt_pkg::mk_res(tt_pkg::K_CHAR, p_byte, tt_pkg::E_NONE,
                                    line_next, len_next);
            n = n + 2'd1;
          end
        end

        if (n != 2'd0) res[n - 2'd1].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= tt_pkg::M_SKIP;
      line_count   <= tt_pkg::LINE_ONE;
      length_count <= '0;
    end else begin
      mode         <= mode_next;
      line_count   <= line_next;
      length_count <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tt_pkg::FIFO_AW'(n);
      if (result_take) rd_ptr <= rd_ptr + tt_pkg::FIFO_AW'(1);
      count <= count + CW'(n) - CW'(result_take);
    end
    for (int i = 0; i < tt_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < n) fifo[wr_ptr + tt_pkg::FIFO_AW'(i)] <= res[i];
    end
  end

  assign kind         = fifo[rd_ptr].kind;
  assign char_out     = fifo[rd_ptr].ch;
  assign error_code   = fifo[rd_ptr].err;
  assign line_number  = fifo[rd_ptr].line;
  assign token_length = fifo[rd_ptr].len;
  assign last         = fifo[rd_ptr].last;

endmodule
